// ===== rtl/core/chhi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// chhi_pkg
// Shared types, widths and the arctangent table for the hard-iron compensated
// compass heading core.
// ============================================================================
package chhi_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN      = 24;
    localparam int DECL_W        = 16;
    localparam int HEAD_OUT_W    = 16;
    // cordic vector: corrected sample (SAMPLE_W+1) scaled by 256, plus growth
    localparam int VEC_W         = SAMPLE_W + 12;
    // angle accumulator in 1/65536 centidegree
    localparam int ANG_W         = 33;
    localparam int FRAC_W        = 16;
    localparam int HEAD_W        = ANG_W - FRAC_W + 1;
    localparam int IDX_W         = 5;

    localparam logic signed [DECL_W-1:0] DECL_RESET = 16'sd60;
    localparam logic signed [ANG_W-1:0]  HALF_TURN_Z = 33'sd1179648000;
    localparam logic signed [ANG_W-1:0]  ROUND_HALF  = 33'sd32768;
    localparam logic signed [HEAD_W-1:0] FULL_TURN   = 18'sd36000;
    localparam logic signed [HEAD_W-1:0] TWO_TURNS   = 18'sd72000;
    localparam logic signed [HEAD_W-1:0] NEG_TURN    = -18'sd36000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw_x;
        logic signed [SAMPLE_W-1:0] raw_y;
    } t_in_item;

    typedef struct packed {
        logic [HEAD_OUT_W-1:0]      heading_centideg;
        logic signed [SAMPLE_W-1:0] offset_x;
        logic signed [SAMPLE_W-1:0] offset_y;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic calc_off;
        logic calc_diff;
        logic cordic_init;
        logic cordic_step;
        logic round_head;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;
    } t_dp_sts;

    // atan(2^-i) in 1/65536 centidegree, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 33'd294912000;
            5'd1:    v = 33'd174096719;
            5'd2:    v = 33'd91987925;
            5'd3:    v = 33'd46694507;
            5'd4:    v = 33'd23437865;
            5'd5:    v = 33'd11730358;
            5'd6:    v = 33'd5866610;
            5'd7:    v = 33'd2933484;
            5'd8:    v = 33'd1466764;
            5'd9:    v = 33'd733385;
            5'd10:   v = 33'd366693;
            5'd11:   v = 33'd183346;
            5'd12:   v = 33'd91673;
            5'd13:   v = 33'd45837;
            5'd14:   v = 33'd22918;
            5'd15:   v = 33'd11459;
            5'd16:   v = 33'd5730;
            5'd17:   v = 33'd2865;
            5'd18:   v = 33'd1432;
            5'd19:   v = 33'd716;
            5'd20:   v = 33'd358;
            5'd21:   v = 33'd179;
            5'd22:   v = 33'd90;
            5'd23:   v = 33'd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/chhi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// chhi_ctrl
// Sequencer for the heading core: input handshake, step sequencing of the
// datapath and the output register valid flag.
// ============================================================================
module chhi_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output chhi_pkg::t_dp_cmd     o_cmd,
    input  wire chhi_pkg::t_dp_sts i_sts
);
    import chhi_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_OFFS  = 7'b0000010,
        S_DIFF  = 7'b0000100,
        S_INIT  = 7'b0001000,
        S_ITER  = 7'b0010000,
        S_ROUND = 7'b0100000,
        S_WRAP  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_OFFS;
                end
            end
            S_OFFS: begin
                o_cmd.calc_off = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.calc_diff = 1'b1;
                n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state = S_ITER;
            end
            S_ITER: begin
                o_cmd.cordic_step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round_head = 1'b1;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/chhi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// chhi_dp
// Datapath: min/max tracking, hard-iron offsets, iterative vectoring CORDIC,
// declination add and wrap into one turn, output register.
// ============================================================================
module chhi_dp #(
    parameter int CORDIC_STEPS = chhi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire chhi_pkg::t_dp_cmd                  i_cmd,
    output chhi_pkg::t_dp_sts                       o_sts,
    input  wire chhi_pkg::t_in_item                 i_in_data,
    input  wire logic                               i_cfg_we,
    input  wire logic signed [chhi_pkg::DECL_W-1:0] i_cfg_data,
    output chhi_pkg::t_out_item                     o_out_data
);
    import chhi_pkg::*;

    localparam int W  = SAMPLE_W;
    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [W-1:0]      r_min_x, r_max_x, r_min_y, r_max_y;
    logic signed [DECL_W-1:0] r_decl;
    logic [CW-1:0]            r_cnt;

    logic signed [W-1:0]      r_x, r_y, r_off_x, r_off_y;
    logic signed [W:0]        r_cs, r_cc;
    logic signed [VEC_W-1:0]  r_vx, r_vy;
    logic signed [ANG_W-1:0]  r_z;
    logic                     r_zero;
    logic signed [HEAD_W-1:0] r_head;
    t_out_item                r_out;

    logic signed [W-1:0]      in_x, in_y;
    logic signed [W:0]        sum_x, sum_y, diff_s, diff_c;
    logic signed [VEC_W-1:0]  init_x, init_y, sh_x, sh_y;
    logic [ANG_W-1:0]         atan_v;
    logic signed [ANG_W-1:0]  z_src, z_rnd;
    logic signed [HEAD_W-1:0] head_sum, head_wrap;

    assign in_x = i_in_data.raw_x;
    assign in_y = i_in_data.raw_y;

    assign sum_x  = {r_max_x[W-1], r_max_x} + {r_min_x[W-1], r_min_x};
    assign sum_y  = {r_max_y[W-1], r_max_y} + {r_min_y[W-1], r_min_y};
    assign diff_s = {r_x[W-1], r_x} - {r_off_x[W-1], r_off_x};
    assign diff_c = {r_y[W-1], r_y} - {r_off_y[W-1], r_off_y};

    // corrected samples scaled by 256, sign extended to the vector width
    assign init_x = {{(VEC_W-W-9){r_cc[W]}}, r_cc, 8'b0};
    assign init_y = {{(VEC_W-W-9){r_cs[W]}}, r_cs, 8'b0};

    assign sh_x   = r_vx >>> r_cnt;
    assign sh_y   = r_vy >>> r_cnt;
    assign atan_v = atan_entry(IDX_W'(r_cnt));

    assign z_src    = r_zero ? '0 : r_z;
    assign z_rnd    = z_src + ROUND_HALF;
    assign head_sum = {z_rnd[ANG_W-1], z_rnd[ANG_W-1:FRAC_W]}
                    + {{(HEAD_W-DECL_W){r_decl[DECL_W-1]}}, r_decl};

    always_comb begin
        if (r_head < NEG_TURN) begin
            head_wrap = r_head + TWO_TURNS;
        end else if (r_head < 0) begin
            head_wrap = r_head + FULL_TURN;
        end else if (r_head >= FULL_TURN) begin
            head_wrap = r_head - FULL_TURN;
        end else begin
            head_wrap = r_head;
        end
    end

    assign o_sts.last_step = (r_cnt == CW'(CORDIC_STEPS - 1));
    assign o_out_data      = r_out;

    // tracking state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
            r_decl  <= DECL_RESET;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_decl <= i_cfg_data;
            end
            if (i_cmd.load_in) begin
                if (in_x > r_max_x) r_max_x <= in_x;
                if (in_x < r_min_x) r_min_x <= in_x;
                if (in_y > r_max_y) r_max_y <= in_y;
                if (in_y < r_min_y) r_min_y <= in_y;
            end
            if (i_cmd.cordic_init) begin
                r_cnt <= '0;
            end else if (i_cmd.cordic_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= in_x;
            r_y <= in_y;
        end
        if (i_cmd.calc_off) begin
            r_off_x <= sum_x[W:1];
            r_off_y <= sum_y[W:1];
        end
        if (i_cmd.calc_diff) begin
            r_cs <= diff_s;
            r_cc <= diff_c;
        end
        if (i_cmd.cordic_init) begin
            r_zero <= (r_cc == '0) && (r_cs == '0);
            // left half plane: turn by half a revolution first
            if (r_cc[W]) begin
                r_vx <= -init_x;
                r_vy <= -init_y;
                r_z  <= HALF_TURN_Z;
            end else begin
                r_vx <= init_x;
                r_vy <= init_y;
                r_z  <= '0;
            end
        end else if (i_cmd.cordic_step) begin
            if (!r_vy[VEC_W-1]) begin
                r_vx <= r_vx + sh_y;
                r_vy <= r_vy - sh_x;
                r_z  <= r_z + $signed(atan_v);
            end else begin
                r_vx <= r_vx - sh_y;
                r_vy <= r_vy + sh_x;
                r_z  <= r_z - $signed(atan_v);
            end
        end
        if (i_cmd.round_head) begin
            r_head <= head_sum;
        end
        if (i_cmd.out_load) begin
            r_out.heading_centideg <= head_wrap[HEAD_OUT_W-1:0];
            r_out.offset_x         <= r_off_x;
            r_out.offset_y         <= r_off_y;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/compass_heading_hard_iron_core.sv =====
// an accepted sample passes the offset, difference, CORDIC init, CORDIC
//   iteration, rounding and wrap states; no new item enters until it is
//   in the output register, one shared CORDIC stage iterating once per cycle
// the output register lets the next item start while a result waits
// reset: synchronous active low; clears min/max to zero, declination to 60
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// compass_heading_hard_iron_core
// Hard-iron compensated magnetometer heading in centidegrees, with running
// offset estimation and configurable declination.
// ============================================================================
module compass_heading_hard_iron_core #(
    parameter int CORDIC_STEPS = chhi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire chhi_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output chhi_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic signed [chhi_pkg::DECL_W-1:0] i_cfg_data
);
    import chhi_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    chhi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    chhi_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

`ifndef SYNTHESIS
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.heading_centideg < 16'd36000))
        else $error("heading outside one turn");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice without processing");

    a_step_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cordic_step |-> !o_in_ready)
        else $error("cordic stepping while ready for input");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("result load did not raise output valid");
`endif

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the hard-iron compensated heading core: a table of
// directed samples and declination writes, then random samples whose spread
// grows over the run so the running offsets keep moving; results are checked
// against pinned values or a cycle-free model of min/max and the CORDIC angle.
// ============================================================================
module testbench;

    import chhi_pkg::*;

    localparam int     STEPS          = 16;
    localparam int     LATENCY        = STEPS + 5;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     PHASE_ITEMS    = 270;
    localparam longint FULL_TURN_CD   = 36000;
    localparam longint HALF_TURN_ANG  = 64'sd1179648000;
    localparam int     PLAN_LEN       = 23;

    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_PINNED} t_row_kind;

    // a/b: sample x/y, or declination for ROW_CFG; the rest only for ROW_PINNED
    typedef struct packed {
        t_row_kind kind;
        int        a;
        int        b;
        int        heading;
        int        off_x;
        int        off_y;
    } t_row;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     in_valid  = 1'b0;
    t_in_item                 in_data   = '0;
    logic                     out_ready = 1'b1;
    logic                     cfg_valid = 1'b0;
    logic signed [DECL_W-1:0] cfg_data  = '0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    t_out_item                o_out_data;
    logic                     o_cfg_ready;

    // pinned expectation travelling with the sample being offered
    logic                     pin_valid  = 1'b0;
    t_out_item                pin_result = '0;

    // model state
    longint                   min_x = 0;
    longint                   max_x = 0;
    longint                   min_y = 0;
    longint                   max_y = 0;
    logic signed [DECL_W-1:0] declination = 16'sd60;

    t_out_item                heading_q [$];
    int                       errors       = 0;
    int                       quiet_cycles = 0;
    int                       send_idle_pct = 0;
    int                       stall_pct     = 0;

    // atan(2^-i) in 1/65536 centidegree
    longint atan_units [0:STEPS-1] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459
    };

    t_row plan [PLAN_LEN] = '{
        '{ROW_PINNED, 0, 0, 60, 0, 0},
        '{ROW_CFG, 18000, 0, 0, 0, 0},
        '{ROW_PINNED, 0, 0, 18000, 0, 0},
        '{ROW_CFG, -18000, 0, 0, 0, 0},
        '{ROW_PINNED, 0, 0, 18000, 0, 0},
        '{ROW_CFG, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 100, 0, 0, 0, 0},
        '{ROW_SAMPLE, 0, 100, 0, 0, 0},
        '{ROW_SAMPLE, 0, -100, 0, 0, 0},
        '{ROW_SAMPLE, -2, -40, 0, 0, 0},
        '{ROW_PINNED, 49, 0, 0, 49, 0},
        '{ROW_SAMPLE, 32767, -32768, 0, 0, 0},
        '{ROW_PINNED, 16382, -16334, 0, 16382, -16334},
        '{ROW_CFG, 32767, 0, 0, 0, 0},
        '{ROW_PINNED, 16382, -16334, 32767, 16382, -16334},
        '{ROW_CFG, -32768, 0, 0, 0, 0},
        '{ROW_PINNED, 16382, -16334, 3232, 16382, -16334},
        '{ROW_CFG, 18000, 0, 0, 0, 0},
        '{ROW_SAMPLE, 16382, -16335, 0, 0, 0},
        '{ROW_SAMPLE, 16382, -16333, 0, 0, 0},
        '{ROW_SAMPLE, 16381, -16334, 0, 0, 0},
        '{ROW_SAMPLE, 32767, 100, 0, 0, 0},
        '{ROW_CFG, 60, 0, 0, 0, 0}
    };

    compass_heading_hard_iron_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // vectoring CORDIC, angle of (cos side c, sin side s)
    function automatic longint cordic_angle(input longint c, input longint s);
        longint vx;
        longint vy;
        longint ang;
        longint tx;
        vx  = c * 256;
        vy  = s * 256;
        ang = 0;
        if (c == 0 && s == 0) begin
            return 0;
        end
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = HALF_TURN_ANG;
        end
        for (int i = 0; i < STEPS; i++) begin
            tx = vx;
            if (vy >= 0) begin
                vx  = vx + (vy >>> i);
                vy  = vy - (tx >>> i);
                ang = ang + atan_units[i];
            end else begin
                vx  = vx - (vy >>> i);
                vy  = vy + (tx >>> i);
                ang = ang - atan_units[i];
            end
        end
        return ang;
    endfunction

    function automatic t_out_item next_heading(input t_in_item s);
        longint    sx;
        longint    sy;
        longint    ox;
        longint    oy;
        longint    hd;
        t_out_item r;
        sx = longint'(s.raw_x);
        sy = longint'(s.raw_y);
        if (sx > max_x) max_x = sx;
        if (sy > max_y) max_y = sy;
        if (sx < min_x) min_x = sx;
        if (sy < min_y) min_y = sy;
        ox = (max_x + min_x) >>> 1;
        oy = (max_y + min_y) >>> 1;
        hd = ((cordic_angle(sy - oy, sx - ox) + 32768) >>> 16) + longint'(declination);
        hd = hd % FULL_TURN_CD;
        if (hd < 0) hd = hd + FULL_TURN_CD;
        r.heading_centideg = hd[15:0];
        r.offset_x         = ox[15:0];
        r.offset_y         = oy[15:0];
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endtask

    // aim: replace the sample by the current offsets, giving a zero vector
    task automatic push_sample(input t_in_item s, input bit aim, input bit pinned,
                               input t_out_item pinned_res);
        t_in_item item;
        item = s;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        if (aim) begin
            item.raw_x = clip16((max_x + min_x) >>> 1);
            item.raw_y = clip16((max_y + min_y) >>> 1);
        end
        in_valid   <= 1'b1;
        in_data    <= item;
        pin_valid  <= pinned;
        pin_result <= pinned_res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_declination(input logic signed [DECL_W-1:0] v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // transaction monitor: model update on input, check on output
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) begin
                declination = cfg_data;
                moved = 1'b1;
            end
            if (in_valid && o_in_ready) begin
                want = next_heading(in_data);
                heading_q.push_back(pin_valid ? pin_result : want);
                moved = 1'b1;
            end
            if (o_out_valid && out_ready) begin
                moved = 1'b1;
                got = o_out_data;
                if (heading_q.size() == 0) begin
                    note_failure($sformatf("unexpected result: heading %0d off %0d,%0d",
                        got.heading_centideg, got.offset_x, got.offset_y));
                end else begin
                    want = heading_q.pop_front();
                    if (got.heading_centideg !== want.heading_centideg ||
                        got.offset_x !== want.offset_x ||
                        got.offset_y !== want.offset_y) begin
                        note_failure($sformatf(
                            "mismatch: expected heading %0d off %0d,%0d got %0d off %0d,%0d",
                            want.heading_centideg, want.offset_x, want.offset_y,
                            got.heading_centideg, got.offset_x, got.offset_y));
                    end
                end
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("compass_heading_hard_iron_core regression: fail");
        $finish;
    end

    initial begin
        t_in_item                 s;
        t_out_item                res;
        logic signed [DECL_W-1:0] decl;
        longint                   amp;
        int                       k;

        k = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].kind == ROW_CFG) begin
                drain_results();
                write_declination(16'(plan[r].a));
            end else begin
                s.raw_x              = 16'(plan[r].a);
                s.raw_y              = 16'(plan[r].b);
                res.heading_centideg = 16'(plan[r].heading);
                res.offset_x         = 16'(plan[r].off_x);
                res.offset_y         = 16'(plan[r].off_y);
                push_sample(s, 1'b0, plan[r].kind == ROW_PINNED, res);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    decl          = 16'sd18000;
                end
                1: begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                    decl          = -16'sd18000;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                    decl          = 16'($signed($urandom_range(0, 36000)) - 18000);
                end
                default: begin
                    send_idle_pct = 33;
                    stall_pct     = 33;
                    decl          = 16'($urandom);
                end
            endcase
            write_declination(decl);
            // spread widens with every sample so the offsets drift over the run
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                amp = 48 + longint'(k) * 40;
                s.raw_x = clip16(longint'($urandom_range(0, 32'(2 * amp))) - amp);
                s.raw_y = clip16(longint'($urandom_range(0, 32'(2 * amp))) - amp);
                push_sample(s, $urandom_range(0, 99) < 4, 1'b0, '0);
                k++;
            end
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (heading_q.size() != 0) note_failure("results still outstanding at end of run");
        if (errors == 0) begin
            $display("compass_heading_hard_iron_core regression: pass");
        end else begin
            $display("compass_heading_hard_iron_core regression: fail");
        end
        $finish;
    end

endmodule
